### sv/pb8_rle_compressor_core_assert.svh
// Assertion macros used by the PB8 RLE compressor emitter
`ifndef PB8_RLE_COMPRESSOR_CORE_ASSERT_SVH
`define PB8_RLE_COMPRESSOR_CORE_ASSERT_SVH

// Check that cons holds in the same cycle as ante
`define PB8_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante
`define PB8_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/pb8_pkg.sv
// Shared types and constants for the PB8 RLE compressor
`default_nettype none

package pb8_pkg;

  // Configuration register
  localparam int unsigned CFG_WIDTH = 16;
  localparam logic [CFG_WIDTH-1:0] GPP_RESET = 16'd1;

  // Classification queue between front and back
  localparam int unsigned QUEUE_DEPTH    = 4;
  localparam int unsigned QUEUE_PTR_BITS = 2;
  localparam int unsigned QUEUE_CNT_BITS = 3;

  // One classified input byte
  typedef struct packed {
    logic [7:0] data;   // raw byte
    logic       lit;    // byte goes to the literal store
    logic [2:0] pos;    // position within the group
    logic       gend;   // group closes on this byte
    logic       last;   // final byte of the stream
  } token_t;

  // Queue status seen by the front and the back
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

`default_nettype wire

### sv/pb8_queue.sv
// Short token queue that decouples the classifier from the emitter
`default_nettype none

module pb8_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire pb8_pkg::token_t push_data,
  input  wire logic            pop,
  output pb8_pkg::token_t      pop_data,
  output pb8_pkg::queue_status_t status
);

  pb8_pkg::token_t                         entries [pb8_pkg::QUEUE_DEPTH];
  logic [pb8_pkg::QUEUE_PTR_BITS-1:0]      wr_ptr;
  logic [pb8_pkg::QUEUE_PTR_BITS-1:0]      rd_ptr;
  logic [pb8_pkg::QUEUE_CNT_BITS-1:0]      fill;

  // Report occupancy
  assign status.full  = (fill == pb8_pkg::QUEUE_CNT_BITS'(pb8_pkg::QUEUE_DEPTH));
  assign status.empty = (fill == '0);
  assign pop_data     = entries[rd_ptr];

  // Store pushed tokens
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### sv/pb8_front.sv
// Classifier: accepts raw bytes, tracks the previous byte and group boundaries
`default_nettype none

module pb8_front #(
  parameter int unsigned PACKET_COUNT_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration write
  input  wire logic                          cfg_valid,
  input  wire logic [pb8_pkg::CFG_WIDTH-1:0] cfg_data,
  // input items
  input  wire logic                          in_valid,
  input  wire logic [7:0]                    in_byte,
  input  wire logic                          in_last,
  output logic                               in_stall,
  // towards the queue
  input  wire pb8_pkg::queue_status_t        q_status,
  output logic                               push,
  output pb8_pkg::token_t                    push_data
);

  logic [pb8_pkg::CFG_WIDTH-1:0]  groups_per_packet;
  logic [7:0]                     prev_byte;
  logic                           prev_valid;
  logic [2:0]                     group_pos;
  logic [PACKET_COUNT_BITS-1:0]   group_count;
  logic [PACKET_COUNT_BITS-1:0]   group_count_next;
  logic [PACKET_COUNT_BITS-1:0]   limit;
  logic                           is_repeat;
  logic                           gend;
  logic                           drop_prev;

  // Classify the incoming byte
  assign in_stall  = q_status.full;
  assign push      = in_valid && !in_stall;
  assign is_repeat = prev_valid && (in_byte == prev_byte);
  assign gend      = (group_pos == 3'd7) || in_last;

  assign push_data.data = in_byte;
  assign push_data.lit  = !is_repeat;
  assign push_data.pos  = group_pos;
  assign push_data.gend = gend;
  assign push_data.last = in_last;

  // Packet boundary: register taken modulo the counter width
  assign limit            = PACKET_COUNT_BITS'(groups_per_packet);
  assign group_count_next = group_count + PACKET_COUNT_BITS'(1);
  assign drop_prev        = gend && (in_last || (group_count_next == limit));

  // Hold the configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      groups_per_packet <= pb8_pkg::GPP_RESET;
    end else if (cfg_valid) begin
      groups_per_packet <= cfg_data;
    end
  end

  // Advance previous byte, group position and packet count
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_byte   <= '0;
      prev_valid  <= 1'b0;
      group_pos   <= '0;
      group_count <= '0;
    end else if (push) begin
      // Drop the previous byte at stream end or after a packet of groups
      if (drop_prev) begin
        prev_byte  <= '0;
        prev_valid <= 1'b0;
      end else if (!is_repeat) begin
        prev_byte  <= in_byte;
        prev_valid <= 1'b1;
      end
      if (gend) begin
        group_pos <= '0;
        if (drop_prev) begin
          group_count <= '0;
        end else begin
          group_count <= group_count_next;
        end
      end else begin
        group_pos <= group_pos + 3'd1;
      end
    end
  end

endmodule

`default_nettype wire

### sv/pb8_back.sv
// Emitter: gathers a group's control bits and literals, then sends them out
`default_nettype none

`include "pb8_rle_compressor_core_assert.svh"

module pb8_back (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // from the queue
  input  wire pb8_pkg::queue_status_t q_status,
  input  wire pb8_pkg::token_t        pop_data,
  output logic                        pop,
  // result items
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [7:0]                  out_byte,
  output logic                        is_control,
  output logic                        group_end,
  output logic                        stream_end
);

  typedef enum logic [1:0] {
    ST_COLLECT = 2'b01,
    ST_EMIT    = 2'b10
  } state_t;

  state_t     state;
  logic [7:0] ctrl_acc;
  logic [3:0] lit_cnt;
  logic [7:0] lit_store [8];
  logic [7:0] emit_ctrl;
  logic [3:0] emit_lits;
  logic       emit_last;
  logic [3:0] emit_idx;
  logic [3:0] idx_m1;
  logic [7:0] ctrl_with_bit;
  logic [3:0] lit_cnt_next;
  logic [3:0] filled;
  logic       load;
  logic       load_end;

  // Fold the popped token into the group
  assign pop           = (state == ST_COLLECT) && !q_status.empty;
  assign ctrl_with_bit = pop_data.lit ? ctrl_acc : (ctrl_acc | (8'h80 >> pop_data.pos));
  assign lit_cnt_next  = pop_data.lit ? (lit_cnt + 4'd1) : lit_cnt;
  assign filled        = {1'b0, pop_data.pos} + 4'd1;

  // In emission, the output register loads whenever it is free or being taken
  assign load     = (state == ST_EMIT) && (!out_valid || !out_stall);
  assign idx_m1   = emit_idx - 4'd1;
  assign load_end = (emit_idx == emit_lits);

  // Gather literals
  always_ff @(posedge clk) begin
    if (pop && pop_data.lit) begin
      lit_store[lit_cnt[2:0]] <= pop_data.data;
    end
  end

  // Latch the finished group for emission
  always_ff @(posedge clk) begin
    if (pop && pop_data.gend) begin
      emit_ctrl <= ctrl_with_bit | (8'hFF >> filled);
      emit_lits <= lit_cnt_next;
      emit_last <= pop_data.last;
    end
  end

  // Step the collect / emit sequence
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_COLLECT;
      ctrl_acc <= '0;
      lit_cnt  <= '0;
      emit_idx <= '0;
    end else begin
      unique case (state)
        ST_COLLECT: begin
          if (pop) begin
            if (pop_data.gend) begin
              ctrl_acc <= '0;
              lit_cnt  <= '0;
              emit_idx <= '0;
              state    <= ST_EMIT;
            end else begin
              ctrl_acc <= ctrl_with_bit;
              lit_cnt  <= lit_cnt_next;
            end
          end
        end
        ST_EMIT: begin
          if (load) begin
            emit_idx <= emit_idx + 4'd1;
            if (load_end) begin
              state <= ST_COLLECT;
            end
          end
        end
        default: begin
          state <= ST_COLLECT;
        end
      endcase
    end
  end

  // Hold the output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Load the output payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_byte   <= (emit_idx == 4'd0) ? emit_ctrl : lit_store[idx_m1[2:0]];
      is_control <= (emit_idx == 4'd0);
      group_end  <= load_end;
      stream_end <= load_end && emit_last;
    end
  end

  `PB8_ASSERT_NOW(a_lit_cnt_range, state == ST_COLLECT, !lit_cnt[3],
    "literal count passed seven inside a group")
  `PB8_ASSERT_NOW(a_emit_lits_range, state == ST_EMIT, emit_lits <= 4'd8,
    "group holds more than eight literals")
  `PB8_ASSERT_NEXT(a_group_close, load && load_end, state == ST_COLLECT,
    "emitter did not return to collect after the group end")
  `PB8_ASSERT_NOW(a_ctrl_first, load && (emit_idx == 4'd0), state == ST_EMIT,
    "control byte loaded outside emission")

endmodule

`default_nettype wire

### sv/pb8_rle_compressor_core.sv
// Top level of the PB8 RLE compressor: classifier, token queue and emitter
//
//   channel  direction  handshake            payload
//   cfg      in         cfg_valid/cfg_ready  cfg_data (groups_per_packet)
//   in       in         in_valid/in_stall    in_byte, in_last
//   out      out        out_valid/out_stall  out_byte, is_control, group_end, stream_end
//
// The classifier takes one byte per cycle while the four-entry queue has room.
// The emitter pops one byte per cycle while the queue holds tokens, then sends the
// group's control byte and its literals, popping nothing until the last is loaded.
// Synchronous reset clears all control state; the register returns to 1.
// A stalled output holds its item; the queue lets input continue until it fills.
`default_nettype none

module pb8_rle_compressor_core #(
  parameter int unsigned PACKET_COUNT_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [pb8_pkg::CFG_WIDTH-1:0] cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [7:0]                    in_byte,
  input  wire logic                          in_last,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [7:0]                         out_byte,
  output logic                               is_control,
  output logic                               group_end,
  output logic                               stream_end
);

  pb8_pkg::queue_status_t q_status;
  pb8_pkg::token_t        push_data;
  pb8_pkg::token_t        pop_data;
  logic                   push;
  logic                   pop;

  // Accept configuration at any time
  assign cfg_ready = 1'b1;

  pb8_front #(
    .PACKET_COUNT_BITS(PACKET_COUNT_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .in_stall  (in_stall),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data)
  );

  pb8_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (q_status)
  );

  pb8_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_status   (q_status),
    .pop_data   (pop_data),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .is_control (is_control),
    .group_end  (group_end),
    .stream_end (stream_end)
  );

endmodule

`default_nettype wire
